// ===== design/drc_pkg.sv =====
`default_nettype none
package drc_pkg;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_NORM,
        S_SQ_ISSUE,
        S_SQ_TAKE,
        S_LVL_ISSUE,
        S_LVL_TAKE,
        S_NT_PREP,
        S_NT_ISSUE,
        S_NT_TAKE,
        S_SM1,
        S_SM2,
        S_SM_TAKE,
        S_TOTAL,
        S_EXP_ISSUE,
        S_EXP_TAKE,
        S_POW,
        S_POW_TAKE,
        S_OUT_ISSUE,
        S_OUT_TAKE,
        S_SAT
    } state_t;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd4;

    // reset values
    localparam logic [15:0] THRESHOLD_RST = 16'hEC00;
    localparam logic [15:0] SLOPE_RST     = 16'd49152;
    localparam logic [15:0] ATTACK_RST    = 16'd65400;
    localparam logic [15:0] RELEASE_RST   = 16'd65522;
    localparam logic [13:0] MAKEUP_RST    = 14'd0;

    // arithmetic constants
    localparam logic [31:0] LVL_SCALE = 32'd394566;     // 20*log10(2), Q16
    localparam logic [31:0] EXP_SCALE = 32'd10885;      // log2(10)/20, Q16
    localparam logic [31:0] EXP_BIAS  = 32'd180191360;  // 2^29 - 32768*10885 + 128
    localparam logic signed [17:0] LVL_FLOOR = -18'sd25600;

    typedef struct packed {
        logic signed [15:0] thresh_lvl;
        logic [15:0]        gain_slope;
        logic [15:0]        atk_coef;
        logic [15:0]        rel_coef;
        logic signed [13:0] makeup_db;
    } cfg_t;

    // 2^(2^-(k+1)) in Q30
    function automatic logic [31:0] pow2_frac(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd0:    r = 32'd1518500250;
            4'd1:    r = 32'd1276901417;
            4'd2:    r = 32'd1170923762;
            4'd3:    r = 32'd1121280436;
            4'd4:    r = 32'd1097253708;
            4'd5:    r = 32'd1085434106;
            4'd6:    r = 32'd1079572136;
            4'd7:    r = 32'd1076653033;
            4'd8:    r = 32'd1075196443;
            4'd9:    r = 32'd1074468888;
            4'd10:   r = 32'd1074105294;
            4'd11:   r = 32'd1073923544;
            4'd12:   r = 32'd1073832680;
            4'd13:   r = 32'd1073787251;
            4'd14:   r = 32'd1073764537;
            default: r = 32'd1073753181;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/drc_mul.sv =====
`default_nettype none
// shared 32x32 multiplier, product registered
module drc_mul (
    input  wire logic        clk,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic [63:0]      prod_reg
);

    logic [63:0] prod_next;

    assign prod_next = {32'd0, op_a} * {32'd0, op_b};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

// ===== design/drc_cfg.sv =====
`default_nettype none
// configuration register file
module drc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [drc_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [15:0]                   wr_data,
    output drc_pkg::cfg_t                      cfg_reg
);

    drc_pkg::cfg_t cfg_next;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                drc_pkg::REG_THRESHOLD: cfg_next.thresh_lvl = wr_data;
                drc_pkg::REG_SLOPE:     cfg_next.gain_slope = wr_data;
                drc_pkg::REG_ATTACK:    cfg_next.atk_coef   = wr_data;
                drc_pkg::REG_RELEASE:   cfg_next.rel_coef   = wr_data;
                drc_pkg::REG_MAKEUP:    cfg_next.makeup_db  = wr_data[13:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh_lvl <= drc_pkg::THRESHOLD_RST;
            cfg_reg.gain_slope <= drc_pkg::SLOPE_RST;
            cfg_reg.atk_coef   <= drc_pkg::ATTACK_RST;
            cfg_reg.rel_coef   <= drc_pkg::RELEASE_RST;
            cfg_reg.makeup_db  <= drc_pkg::MAKEUP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/dynamic_range_compressor_core.sv =====
// a new word is taken only in idle, after the last has reached the output register;
// a silent word skips the normalise and log steps
// the single shared 32x32 multiplier carries 16 log squarings, the level scale, the
// slope product, smoother, up to 16 exp steps and the output scaling
// reset: envelope to 0 dB, config registers to their defaults, no clearing pass
`default_nettype none
module dynamic_range_compressor_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]     sample_out,
    output logic signed [15:0]                 applied_gain_db,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [drc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data
);

    localparam int W = SAMPLE_WIDTH;
    localparam int FLOOR_LIM = ((1 << (W - 1)) + 99999) / 100000;

    drc_pkg::state_t state_reg, state_next;
    drc_pkg::cfg_t   cfg;

    logic [W-1:0]        a_reg, a_next;
    logic                neg_reg, neg_next;
    logic [31:0]         m_reg, m_next;
    logic [4:0]          s_reg, s_next;
    logic [15:0]         frac_reg, frac_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic signed [17:0]  lvl_reg, lvl_next;
    logic [16:0]         diff_reg, diff_next;
    logic [31:0]         nt_reg, nt_next;
    logic [15:0]         coef_reg, coef_next;
    logic [47:0]         acc_reg, acc_next;
    logic [31:0]         env_reg, env_next;
    logic signed [15:0]  total_reg, total_next;
    logic [15:0]         f_reg, f_next;
    logic [5:0]          sh_reg, sh_next;
    logic [31:0]         g_reg, g_next;
    logic [45:0]         mag_reg, mag_next;
    logic                out_valid_reg, out_valid_next;
    logic [W-1:0]        sample_out_reg, sample_out_next;
    logic [15:0]         gain_out_reg, gain_out_next;

    logic [31:0]         op_a, op_b;
    logic [63:0]         prod;

    logic [W-1:0]        in_abs;
    logic [32:0]         sq_t;
    logic [41:0]         lvl_sum;
    logic signed [17:0]  d;
    logic [63:0]         sm_sum;
    logic [32:0]         ne_round;
    logic signed [17:0]  tot;
    logic [31:0]         wv;
    logic [63:0]         pw_sum;
    logic [63:0]         out_sum;
    logic [63:0]         out_shift;
    logic [45:0]         lim;
    logic [45:0]         mag_c;
    logic [W-1:0]        mag_w;

    drc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg_reg  (cfg)
    );

    drc_mul u_mul (
        .clk      (clk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod)
    );

    assign cfg_ready       = 1'b1;
    assign in_ready        = (state_reg == drc_pkg::S_IDLE);
    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_out_reg;
    assign applied_gain_db = gain_out_reg;

    // magnitude of the incoming word
    assign in_abs = sample_in[W-1] ? (~sample_in + 1'b1) : sample_in;

    // datapath terms
    assign sq_t      = prod[63:31];
    assign lvl_sum   = prod[41:0] + (42'd1 << 23);
    assign d         = lvl_reg - {{2{cfg.thresh_lvl[15]}}, cfg.thresh_lvl};
    assign sm_sum    = {16'd0, acc_reg} + prod + 64'd32768;
    assign ne_round  = {1'b0, env_reg} + 33'd32768;
    assign tot       = {{4{cfg.makeup_db[13]}}, cfg.makeup_db} - {1'b0, ne_round[32:16]};
    assign wv        = prod[31:0] + drc_pkg::EXP_BIAS;
    assign pw_sum    = prod + (64'd1 << 29);
    assign out_sum   = prod + (64'd1 << (sh_reg - 6'd1));
    assign out_shift = out_sum >> sh_reg;
    assign lim       = (46'd1 << (W - 1)) - {45'd0, ~neg_reg};
    assign mag_c     = (mag_reg > lim) ? lim : mag_reg;
    assign mag_w     = mag_c[W-1:0];

    // multiplier operand select
    always_comb
    begin
        op_a = 32'd0;
        op_b = 32'd0;
        unique case (state_reg)
            drc_pkg::S_SQ_ISSUE:
            begin
                op_a = m_reg;
                op_b = m_reg;
            end
            drc_pkg::S_LVL_ISSUE:
            begin
                op_a = 32'({s_reg, 16'd0} - {5'd0, frac_reg});
                op_b = drc_pkg::LVL_SCALE;
            end
            drc_pkg::S_NT_ISSUE:
            begin
                op_a = 32'(diff_reg);
                op_b = 32'(cfg.gain_slope);
            end
            drc_pkg::S_SM1:
            begin
                op_a = (nt_reg > env_reg) ? 32'(cfg.atk_coef) : 32'(cfg.rel_coef);
                op_b = env_reg;
            end
            drc_pkg::S_SM2:
            begin
                op_a = 32'(17'h10000 - {1'b0, coef_reg});
                op_b = nt_reg;
            end
            drc_pkg::S_EXP_ISSUE:
            begin
                op_a = {16'd0, ~total_reg[15], total_reg[14:0]};
                op_b = drc_pkg::EXP_SCALE;
            end
            drc_pkg::S_POW:
            begin
                op_a = g_reg;
                op_b = drc_pkg::pow2_frac(cnt_reg);
            end
            drc_pkg::S_OUT_ISSUE:
            begin
                op_a = 32'(a_reg);
                op_b = g_reg;
            end
            default:
            begin
                op_a = 32'd0;
                op_b = 32'd0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        neg_next        = neg_reg;
        m_next          = m_reg;
        s_next          = s_reg;
        frac_next       = frac_reg;
        cnt_next        = cnt_reg;
        lvl_next        = lvl_reg;
        diff_next       = diff_reg;
        nt_next         = nt_reg;
        coef_next       = coef_reg;
        acc_next        = acc_reg;
        env_next        = env_reg;
        total_next      = total_reg;
        f_next          = f_reg;
        sh_next         = sh_reg;
        g_next          = g_reg;
        mag_next        = mag_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        sample_out_next = sample_out_reg;
        gain_out_next   = gain_out_reg;

        unique case (state_reg)
            drc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next    = in_abs;
                    neg_next  = sample_in[W-1];
                    m_next    = {in_abs, {(32 - W){1'b0}}};
                    s_next    = 5'd0;
                    frac_next = 16'd0;
                    cnt_next  = 4'd0;
                    if (in_abs < W'(FLOOR_LIM))
                    begin
                        lvl_next   = drc_pkg::LVL_FLOOR;
                        state_next = drc_pkg::S_NT_PREP;
                    end
                    else
                    begin
                        state_next = drc_pkg::S_NORM;
                    end
                end
            end
            // normalise one bit a cycle
            drc_pkg::S_NORM:
            begin
                if (m_reg[31])
                begin
                    state_next = drc_pkg::S_SQ_ISSUE;
                end
                else
                begin
                    m_next = {m_reg[30:0], 1'b0};
                    s_next = s_reg + 5'd1;
                end
            end
            drc_pkg::S_SQ_ISSUE:
            begin
                state_next = drc_pkg::S_SQ_TAKE;
            end
            // one log2 fraction bit per squaring
            drc_pkg::S_SQ_TAKE:
            begin
                frac_next = {frac_reg[14:0], sq_t[32]};
                m_next    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = drc_pkg::S_LVL_ISSUE;
                end
                else
                begin
                    state_next = drc_pkg::S_SQ_ISSUE;
                end
            end
            drc_pkg::S_LVL_ISSUE:
            begin
                state_next = drc_pkg::S_LVL_TAKE;
            end
            drc_pkg::S_LVL_TAKE:
            begin
                lvl_next   = 18'sd0 - $signed({1'b0, lvl_sum[40:24]});
                state_next = drc_pkg::S_NT_PREP;
            end
            // overshoot above threshold
            drc_pkg::S_NT_PREP:
            begin
                diff_next = d[16:0];
                if (!d[17] && (d != 18'sd0))
                begin
                    state_next = drc_pkg::S_NT_ISSUE;
                end
                else
                begin
                    nt_next    = 32'd0;
                    state_next = drc_pkg::S_SM1;
                end
            end
            drc_pkg::S_NT_ISSUE:
            begin
                state_next = drc_pkg::S_NT_TAKE;
            end
            drc_pkg::S_NT_TAKE:
            begin
                nt_next    = prod[31:0];
                state_next = drc_pkg::S_SM1;
            end
            // smoother, attack when the target attenuation is larger
            drc_pkg::S_SM1:
            begin
                coef_next  = (nt_reg > env_reg) ? cfg.atk_coef : cfg.rel_coef;
                state_next = drc_pkg::S_SM2;
            end
            drc_pkg::S_SM2:
            begin
                acc_next   = prod[47:0];
                state_next = drc_pkg::S_SM_TAKE;
            end
            drc_pkg::S_SM_TAKE:
            begin
                env_next   = sm_sum[47:16];
                state_next = drc_pkg::S_TOTAL;
            end
            // total gain with makeup, saturated
            drc_pkg::S_TOTAL:
            begin
                if (tot < -18'sd32768)
                begin
                    total_next = 16'sh8000;
                end
                else if (tot > 18'sd32767)
                begin
                    total_next = 16'sh7FFF;
                end
                else
                begin
                    total_next = tot[15:0];
                end
                state_next = drc_pkg::S_EXP_ISSUE;
            end
            drc_pkg::S_EXP_ISSUE:
            begin
                state_next = drc_pkg::S_EXP_TAKE;
            end
            drc_pkg::S_EXP_TAKE:
            begin
                f_next     = wv[23:8];
                sh_next    = 6'd62 - wv[29:24];
                g_next     = 32'd1 << 30;
                cnt_next   = 4'd0;
                state_next = drc_pkg::S_POW;
            end
            // exp: one fraction bit per step, multiply only where set
            drc_pkg::S_POW:
            begin
                if (f_reg[15])
                begin
                    state_next = drc_pkg::S_POW_TAKE;
                end
                else
                begin
                    f_next   = {f_reg[14:0], 1'b0};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_next = drc_pkg::S_OUT_ISSUE;
                    end
                end
            end
            drc_pkg::S_POW_TAKE:
            begin
                g_next   = pw_sum[61:30];
                f_next   = {f_reg[14:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = drc_pkg::S_OUT_ISSUE;
                end
                else
                begin
                    state_next = drc_pkg::S_POW;
                end
            end
            drc_pkg::S_OUT_ISSUE:
            begin
                state_next = drc_pkg::S_OUT_TAKE;
            end
            drc_pkg::S_OUT_TAKE:
            begin
                mag_next   = out_shift[45:0];
                state_next = drc_pkg::S_SAT;
            end
            // saturate and hand over once the output register is free
            drc_pkg::S_SAT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    sample_out_next = neg_reg ? (~mag_w + 1'b1) : mag_w;
                    gain_out_next   = total_reg;
                    out_valid_next  = 1'b1;
                    state_next      = drc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = drc_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            env_reg       <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            env_reg       <= env_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        neg_reg        <= neg_next;
        m_reg          <= m_next;
        s_reg          <= s_next;
        frac_reg       <= frac_next;
        cnt_reg        <= cnt_next;
        lvl_reg        <= lvl_next;
        diff_reg       <= diff_next;
        nt_reg         <= nt_next;
        coef_reg       <= coef_next;
        acc_reg        <= acc_next;
        total_reg      <= total_next;
        f_reg          <= f_next;
        sh_reg         <= sh_next;
        g_reg          <= g_next;
        mag_reg        <= mag_next;
        sample_out_reg <= sample_out_next;
        gain_out_reg   <= gain_out_next;
    end

`ifndef NO_ASSERTIONS
    // an accepted word always starts the sequencer
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != drc_pkg::S_IDLE))
        else $error("sequencer did not start");

    // linear gain stays within one octave above unity
    a_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drc_pkg::S_OUT_ISSUE) |-> (g_reg[31:30] == 2'b01))
        else $error("linear gain out of range");

    // output shift stays within the saturated gain range
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drc_pkg::S_OUT_TAKE) |-> (sh_reg >= 6'd9 && sh_reg <= 6'd52))
        else $error("output shift out of range");

    // a new word only appears from the saturation step
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == drc_pkg::S_SAT))
        else $error("output loaded outside saturation step");
`endif

endmodule
`default_nettype wire
